/* rtl/core/dmht_pkg.sv */
// ----------------------------------------------------------------------------
// dmht_pkg
// shared constants for the direct-mapped hash table lookup unit
// ----------------------------------------------------------------------------
`default_nettype none

package dmht_pkg;

  localparam int OP_W     = 2;
  localparam int KEY_W    = 64;
  localparam int HASH_W   = 32;
  localparam int SLOT_W   = 12;
  localparam int USED_W   = 13;
  localparam int CNT_W    = 48;

  localparam logic [OP_W-1:0] OP_LOOKUP     = 2'd0;
  localparam logic [OP_W-1:0] OP_NEW_SEARCH = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR      = 2'd2;

endpackage

`default_nettype wire

/* rtl/core/direct_mapped_hash_table_lookup_unit.sv */
// ----------------------------------------------------------------------------
// direct_mapped_hash_table_lookup_unit
// direct-mapped key table, always-replace, with per-entry age and statistics
// ----------------------------------------------------------------------------
// usage:
//   input channel (in_valid/in_ready) carries operation and key; every word
//   gives one result word on the output channel (out_valid/out_ready) with
//   hit, slot and the statistics as they stand after the operation.
//   a lookup passes the remainder pipeline (reciprocal multiply, quotient
//   multiply, correcting subtraction), then the table read, then compare and
//   write-back into the single table ram, where the result is registered;
//   the next word is accepted only after that.
//   new search and the unused code go straight to the result step.
//   clear sweeps the table one entry a cycle, then gives its result.
//   after reset the same sweep runs over all ENTRIES entries with in_ready
//   low and no result.
//   results sit in an output register; a new word is accepted while a
//   result waits, and work stalls at the final step until that register is
//   free, so a stalled receiver holds back at most one item in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module direct_mapped_hash_table_lookup_unit #(
  parameter int ENTRIES  = 4096,
  parameter int AGE_BITS = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [dmht_pkg::OP_W-1:0]     operation,
  input  wire logic [dmht_pkg::KEY_W-1:0]    key,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic                               hit,
  output logic      [dmht_pkg::SLOT_W-1:0]   slot,
  output logic      [dmht_pkg::USED_W-1:0]   used_count,
  output logic      [dmht_pkg::CNT_W-1:0]    lookup_total,
  output logic      [dmht_pkg::CNT_W-1:0]    hit_total,
  output logic      [dmht_pkg::CNT_W-1:0]    collision_total
);

  localparam int AW    = $clog2(ENTRIES);
  localparam int UW    = $clog2(ENTRIES + 1);
  localparam int KW    = dmht_pkg::KEY_W;
  localparam int CW    = dmht_pkg::CNT_W;
  localparam int DW    = KW + AGE_BITS;
  localparam logic [AW-1:0] LAST_ADDR = AW'(ENTRIES - 1);
  localparam logic [UW-1:0] USED_MAX  = UW'(ENTRIES);

  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_IX1  = 3'd2;
  localparam logic [2:0] S_IX2  = 3'd3;
  localparam logic [2:0] S_IX3  = 3'd4;
  localparam logic [2:0] S_RD   = 3'd5;
  localparam logic [2:0] S_CMP  = 3'd6;
  localparam logic [2:0] S_DONE = 3'd7;

  logic [2:0]          state;
  logic [KW-1:0]       key_r;
  logic [AGE_BITS-1:0] search_count;
  logic [UW-1:0]       used_counter;
  logic [CW-1:0]       lookup_counter;
  logic [CW-1:0]       hit_counter;
  logic [CW-1:0]       collision_counter;
  logic [AW-1:0]       clr_cnt;
  logic                clr_reply;

  logic [AW-1:0]       idx;
  logic                we;
  logic [AW-1:0]       waddr;
  logic [DW-1:0]       wdata;
  logic                re;
  logic [DW-1:0]       rdata;

  logic [KW-1:0]       old_key;
  logic [AGE_BITS-1:0] old_age;
  logic                match;
  logic                out_free;
  logic                out_fire;
  logic [UW-1:0]       used_next;
  logic [CW-1:0]       lookup_next;
  logic [CW-1:0]       hit_next;
  logic [CW-1:0]       collision_next;
  logic [31:0]         used_ext;
  logic [31:0]         idx_ext;
  logic [31:0]         used_now_ext;

  dmht_index #(
    .ENTRIES (ENTRIES)
  ) u_index (
    .clk  (clk),
    .hash (key_r[KW-1 -: dmht_pkg::HASH_W]),
    .idx  (idx)
  );

  dmht_ram #(
    .WIDTH (DW),
    .DEPTH (ENTRIES)
  ) u_table (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (idx),
    .rdata (rdata)
  );

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;
  assign out_fire = ((state == S_CMP) || (state == S_DONE)) && out_free;

  assign we    = (state == S_CLR) || ((state == S_CMP) && out_free);
  assign waddr = (state == S_CLR) ? clr_cnt : idx;
  assign wdata = (state == S_CLR) ? '0 : {key_r, search_count};
  assign re    = (state == S_RD);

  assign old_key = rdata[DW-1 -: KW];
  assign old_age = rdata[AGE_BITS-1:0];
  assign match   = (old_key == key_r);

  always_comb begin
    used_next      = used_counter;
    lookup_next    = lookup_counter + CW'(1);
    hit_next       = hit_counter;
    collision_next = collision_counter;
    if (match) begin
      hit_next = hit_counter + CW'(1);
    end else if (old_key != '0) begin
      if (old_age == search_count) begin
        collision_next = collision_counter + CW'(1);
      end
    end else if (used_counter < USED_MAX) begin
      used_next = used_counter + UW'(1);
    end
  end

  assign used_ext     = 32'(used_next);
  assign used_now_ext = 32'(used_counter);
  assign idx_ext      = 32'(idx);

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= S_CLR;
      clr_cnt           <= '0;
      clr_reply         <= 1'b0;
      out_valid         <= 1'b0;
      search_count      <= '0;
      used_counter      <= '0;
      lookup_counter    <= '0;
      hit_counter       <= '0;
      collision_counter <= '0;
    end else begin
      out_valid <= out_fire || (out_valid && !out_ready);
      case (state)
        S_CLR: begin
          clr_cnt <= clr_cnt + AW'(1);
          if (clr_cnt == LAST_ADDR) begin
            state <= clr_reply ? S_DONE : S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            key_r <= key;
            case (operation)
              dmht_pkg::OP_LOOKUP: begin
                state <= S_IX1;
              end
              dmht_pkg::OP_NEW_SEARCH: begin
                search_count <= search_count + AGE_BITS'(1);
                state        <= S_DONE;
              end
              dmht_pkg::OP_CLEAR: begin
                search_count      <= '0;
                used_counter      <= '0;
                lookup_counter    <= '0;
                hit_counter       <= '0;
                collision_counter <= '0;
                clr_cnt           <= '0;
                clr_reply         <= 1'b1;
                state             <= S_CLR;
              end
              default: begin
                state <= S_DONE;
              end
            endcase
          end
        end
        S_IX1: state <= S_IX2;
        S_IX2: state <= S_IX3;
        S_IX3: state <= S_RD;
        S_RD:  state <= S_CMP;
        S_CMP: begin
          if (out_free) begin
            used_counter      <= used_next;
            lookup_counter    <= lookup_next;
            hit_counter       <= hit_next;
            collision_counter <= collision_next;
            hit               <= match;
            slot              <= idx_ext[dmht_pkg::SLOT_W-1:0];
            used_count        <= used_ext[dmht_pkg::USED_W-1:0];
            lookup_total      <= lookup_next;
            hit_total         <= hit_next;
            collision_total   <= collision_next;
            state             <= S_IDLE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            hit             <= 1'b0;
            slot            <= '0;
            used_count      <= used_now_ext[dmht_pkg::USED_W-1:0];
            lookup_total    <= lookup_counter;
            hit_total       <= hit_counter;
            collision_total <= collision_counter;
            state           <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

/* rtl/core/dmht_ram.sv */
// ----------------------------------------------------------------------------
// dmht_ram
// generic simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module dmht_ram #(
  parameter int WIDTH = 80,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* rtl/core/dmht_index.sv */
// ----------------------------------------------------------------------------
// dmht_index
// three-stage remainder of the upper key half by the entry count
// ----------------------------------------------------------------------------
`default_nettype none

module dmht_index #(
  parameter int ENTRIES = 4096
) (
  input  wire logic                              clk,
  input  wire logic [dmht_pkg::HASH_W-1:0]       hash,
  output logic      [$clog2(ENTRIES)-1:0]        idx
);

  localparam int AW = $clog2(ENTRIES);
  localparam int HW = dmht_pkg::HASH_W;
  localparam int QW = HW + AW + 1;
  localparam logic [63:0] RECIP64 = (64'd1 << (HW + AW)) / 64'(ENTRIES);
  localparam logic [HW:0] RECIP   = RECIP64[HW:0];
  localparam logic [AW:0] DIVISOR = (AW + 1)'(ENTRIES);

  logic [2*HW:0]   prod;
  logic [HW-1:0]   hash_d1;
  logic [HW-1:0]   hash_d2;
  logic [HW-1:0]   quot;
  logic [QW-1:0]   qe;
  logic [AW:0]     rem;

  // estimated quotient is exact or one low
  assign quot = HW'(prod >> (HW + AW));
  assign rem  = (AW + 1)'(hash_d2) - (AW + 1)'(qe);

  always_ff @(posedge clk) begin
    prod    <= (2 * HW + 1)'(hash) * (2 * HW + 1)'(RECIP);
    hash_d1 <= hash;
    qe      <= QW'(quot) * QW'(DIVISOR);
    hash_d2 <= hash_d1;
    if (rem >= DIVISOR) begin
      idx <= AW'(rem - DIVISOR);
    end else begin
      idx <= AW'(rem);
    end
  end

endmodule

`default_nettype wire

/* rtl/core/dmht_checker.sv */
// ----------------------------------------------------------------------------
// dmht_checker
// port-level checks for the direct-mapped hash table lookup unit
// ----------------------------------------------------------------------------
`default_nettype none

module dmht_checker #(
  parameter int ENTRIES = 4096
) (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          in_valid,
  input wire logic                          in_ready,
  input wire logic [dmht_pkg::OP_W-1:0]     operation,
  input wire logic [dmht_pkg::KEY_W-1:0]    key,
  input wire logic                          out_valid,
  input wire logic                          out_ready,
  input wire logic                          hit,
  input wire logic [dmht_pkg::SLOT_W-1:0]   slot,
  input wire logic [dmht_pkg::USED_W-1:0]   used_count,
  input wire logic [dmht_pkg::CNT_W-1:0]    lookup_total,
  input wire logic [dmht_pkg::CNT_W-1:0]    hit_total,
  input wire logic [dmht_pkg::CNT_W-1:0]    collision_total
);

  // stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid &&
      $stable({hit, slot, used_count, lookup_total, hit_total, collision_total}))
    else $error("result word changed while stalled");

  // no result right after reset
  a_rst_out: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // table sweep holds off input after reset
  a_rst_in: assert property (@(posedge clk) rst |=> !in_ready)
    else $error("input taken during reset sweep");

  // fill count never exceeds table size (checked when ENTRIES is below 8192)
  a_used_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (ENTRIES >= 8192) || (32'(used_count) <= ENTRIES))
    else $error("used count above entry count");

endmodule

bind direct_mapped_hash_table_lookup_unit dmht_checker #(
  .ENTRIES (ENTRIES)
) u_dmht_checker (.*);

`default_nettype wire
